// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pcs_pkg.sv -----
package pcs_pkg;

    // Default depth of the mark store.
    localparam int DEF_MAX_LIMIT = 65536;

    // Fixed payload widths.
    localparam int LIMIT_W = 17;
    localparam int COUNT_W = 13;

    // Saturation value of the prime count.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_CHECK,
        S_MARK,
        S_COUNT,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_init;
        logic scan_rd;
        logic scan_next;
        logic mark_init;
        logic mark_step;
        logic cnt_init;
        logic cnt_rd;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic is_marked;
        logic mark_done;
        logic cnt_done;
    } t_sts;

endpackage

// ----- hw/rtl/pcs_if.sv -----
// Input channel: one upper limit per item.
interface pcs_in_if import pcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

// Output channel: one prime count per item.
interface pcs_out_if import pcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

// ----- hw/rtl/pcs_ctrl.sv -----
module pcs_ctrl import pcs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_busy,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence clear, sieve and count passes.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.clr_step = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.cnt_init = 1'b1;
                    n_state        = S_COUNT;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.is_marked) begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.mark_init = 1'b1;
                    n_state         = S_MARK;
                end
            end
            S_MARK: begin
                if (i_sts.mark_done) begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.mark_step = 1'b1;
                end
            end
            S_COUNT: begin
                if (i_sts.cnt_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.cnt_rd = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/pcs_datapath.sv -----
module pcs_datapath import pcs_pkg::*; #(
    parameter int MAX_LIMIT = DEF_MAX_LIMIT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LIMIT_W-1:0] i_limit,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic [COUNT_W-1:0] o_count
);

    localparam int AW = $clog2(MAX_LIMIT);
    localparam int NW = $clog2(MAX_LIMIT + 1);
    localparam int CW = (NW > LIMIT_W) ? NW : LIMIT_W;

    logic               mem [MAX_LIMIT];
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_k;
    logic [NW-1:0]      r_i;
    logic [NW:0]        r_sq;
    logic [NW:0]        r_j;
    logic [COUNT_W-1:0] r_count;
    logic               r_rd_data;
    logic               r_pend;
    logic [NW-1:0]      w_eff;
    logic [CW-1:0]      w_lim_ext;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [AW-1:0]      w_rd_addr;

    // Saturate the limit to the store depth.
    always_comb begin
        w_lim_ext = CW'(i_limit);
        if (w_lim_ext > CW'(MAX_LIMIT)) begin
            w_eff = NW'(MAX_LIMIT);
        end else begin
            w_eff = NW'(i_limit);
        end
    end

    // Steer the mark store ports.
    assign w_wr_en   = i_cmd.clr_step | i_cmd.mark_step;
    assign w_wr_addr = i_cmd.clr_step ? r_k[AW-1:0] : r_j[AW-1:0];
    assign w_rd_addr = i_cmd.scan_rd ? r_i[AW-1:0] : r_k[AW-1:0];

    // Mark store with registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_cmd.mark_step;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    // Advance the clear and count address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= w_eff;
            r_k <= '0;
        end else if (i_cmd.cnt_init) begin
            r_k <= NW'(2);
        end else if (i_cmd.clr_step || i_cmd.cnt_rd) begin
            r_k <= r_k + NW'(1);
        end
    end

    // Advance the sieving base and its square.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_i  <= NW'(2);
            r_sq <= (NW + 1)'(4);
        end else if (i_cmd.scan_next) begin
            r_i  <= r_i + NW'(1);
            r_sq <= r_sq + {r_i, 1'b1};
        end
    end

    // Walk the multiples of the current base.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_init) begin
            r_j <= r_sq;
        end else if (i_cmd.mark_step) begin
            r_j <= r_j + {1'b0, r_i};
        end
    end

    // Track reads in flight during the count pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.cnt_rd;
        end
    end

    // Count unmarked entries, saturating.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_init) begin
            r_count <= '0;
        end else if (r_pend && !r_rd_data && (r_count != COUNT_MAX)) begin
            r_count <= r_count + COUNT_W'(1);
        end
    end

    assign o_sts.clr_done  = (r_k >= r_n);
    assign o_sts.scan_done = (r_sq >= {1'b0, r_n});
    assign o_sts.is_marked = r_rd_data;
    assign o_sts.mark_done = (r_j >= {1'b0, r_n});
    assign o_sts.cnt_done  = (r_k >= r_n);
    assign o_count         = r_count;

endmodule

// ----- hw/rtl/prime_count_sieve.sv -----
// Each job works on n = min(limit, MAX_LIMIT) entries of the mark store.
// Throughput: one item per job; a new item is taken once the previous job has ended.
// The finished count waits in an output register, so the next item may enter meanwhile.
// Reset (synchronous, active low) clears the controller and output valid; the mark store
// is not reset, each job clears its first n entries before sieving.
module prime_count_sieve import pcs_pkg::*; #(
    parameter int MAX_LIMIT = DEF_MAX_LIMIT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcs_in_if.sink    i_in,
    pcs_out_if.source o_out
);

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [COUNT_W-1:0] w_count;
    logic               w_out_busy;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;

    assign w_out_busy = r_out_valid && !o_out.ready;

    pcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_busy (w_out_busy),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    pcs_datapath #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (i_in.limit),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_count (w_count)
    );

    // Hold the finished item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_count <= w_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.prime_count = r_out_count;

endmodule

// ----- hw/rtl/pcs_checker.sv -----
`include "assert_macros.svh"

module pcs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // A stalled result stays offered.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "out item dropped while stalled")

    // One job at a time: input closes right after an item is taken.
    `ASSERT_NXT(a_in_closed, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input open during a job")

    // A job never finishes in the cycle after its item is taken.
    `ASSERT_NXT(a_no_early, i_clk, i_rst_n, i_in_valid && i_in_ready, !$rose(i_out_valid), "result appeared too early")

    // No result rises while the input is open and idle.
    `ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, i_in_ready && $past(i_in_ready), !$rose(i_out_valid), "result without a job")

endmodule

bind prime_count_sieve pcs_checker u_pcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

// ----- sim/prime_count_sieve_test.sv -----
module prime_count_sieve_test;
    import pcs_pkg::*;

    localparam int MAX_LIMIT      = DEF_MAX_LIMIT;
    localparam int RANDOM_ITEMS   = 75;
    localparam int NO_KNOWN_COUNT = -1;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_AT_COUNT  = 30;
    localparam int HOLD_CYCLES    = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcs_in_if  in_ch ();
    pcs_out_if out_ch ();

    prime_count_sieve #(
        .MAX_LIMIT(MAX_LIMIT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Limits to send, with the count where it is known up front.
    logic [LIMIT_W-1:0] limit_list [$];
    int                 known_list [$];
    // Counts still owed by the block, oldest first.
    logic [COUNT_W-1:0] pending_counts [$];

    bit sieve_marks [MAX_LIMIT];
    int fail_count   = 0;
    int counts_seen  = 0;
    bit sending_done = 1'b0;
    int idle_cycles  = 0;

    always #10 i_clk = ~i_clk;

    // Count the primes below a limit, saturating the limit to the store depth.
    function automatic logic [COUNT_W-1:0] count_primes_below(logic [LIMIT_W-1:0] raw);
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned total;
        n     = raw;
        total = 0;
        if (n > MAX_LIMIT) n = MAX_LIMIT;
        for (i = 0; i < MAX_LIMIT; i++) sieve_marks[i] = 1'b0;
        if (n < 3) return '0;
        sieve_marks[0] = 1'b1;
        sieve_marks[1] = 1'b1;
        for (i = 2; i * i < n; i++) begin
            if (!sieve_marks[i]) begin
                for (j = i * i; j < n; j += i) sieve_marks[j] = 1'b1;
            end
        end
        for (i = 2; i < n; i++) begin
            if (!sieve_marks[i]) total++;
        end
        if (total > COUNT_MAX) total = COUNT_MAX;
        return total[COUNT_W-1:0];
    endfunction

    // Mostly small limits keep jobs short; a few span the whole store.
    function automatic logic [LIMIT_W-1:0] pick_limit();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return LIMIT_W'($urandom_range(0, (1 << LIMIT_W) - 1));
        if (roll < 14) return LIMIT_W'($urandom_range(256, 2047));
        return LIMIT_W'($urandom_range(0, 255));
    endfunction

    task automatic add_row(logic [LIMIT_W-1:0] lim, int known);
        limit_list.push_back(lim);
        known_list.push_back(known);
    endtask

    // Reset, then wait for every owed count to drain.
    initial begin
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(sending_done && pending_counts.size() == 0)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Sender: directed rows, then random limits, in bursts with gaps.
    initial begin
        int sent;
        int burst_left;
        int gap_left;
        in_ch.valid <= 1'b0;
        in_ch.limit <= '0;
        sent       = 0;
        burst_left = 1;
        gap_left   = 0;

        // Small limits, square boundaries, store edge and saturation.
        add_row(17'd0, 0);
        add_row(17'd1, 0);
        add_row(17'd2, 0);
        add_row(17'd3, NO_KNOWN_COUNT);
        add_row(17'd4, NO_KNOWN_COUNT);
        add_row(17'd5, NO_KNOWN_COUNT);
        add_row(17'd6, NO_KNOWN_COUNT);
        add_row(17'd8, NO_KNOWN_COUNT);
        add_row(17'd9, NO_KNOWN_COUNT);
        add_row(17'd10, NO_KNOWN_COUNT);
        add_row(17'd11, NO_KNOWN_COUNT);
        add_row(17'd12, NO_KNOWN_COUNT);
        add_row(17'd25, NO_KNOWN_COUNT);
        add_row(17'd26, NO_KNOWN_COUNT);
        add_row(17'd49, NO_KNOWN_COUNT);
        add_row(17'd50, NO_KNOWN_COUNT);
        add_row(17'd100, NO_KNOWN_COUNT);
        add_row(17'd101, NO_KNOWN_COUNT);
        add_row(17'd102, NO_KNOWN_COUNT);
        add_row(17'd1000, NO_KNOWN_COUNT);
        add_row(17'd4096, NO_KNOWN_COUNT);
        add_row(17'd65536, 6542);
        add_row(17'h1FFFF, 6542);
        add_row(17'd7, NO_KNOWN_COUNT);
        add_row(17'd360, NO_KNOWN_COUNT);
        for (int k = 0; k < RANDOM_ITEMS; k++) add_row(pick_limit(), NO_KNOWN_COUNT);

        do @(posedge i_clk); while (!i_rst_n);

        while (sent < limit_list.size()) begin
            @(posedge i_clk);
            // Log the accepted item and its expected count.
            if (in_ch.valid && in_ch.ready) begin
                if (known_list[sent] == NO_KNOWN_COUNT)
                    pending_counts.push_back(count_primes_below(in_ch.limit));
                else
                    pending_counts.push_back(known_list[sent][COUNT_W-1:0]);
                sent++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Hold the offered item until it is taken.
            end else if (sent < limit_list.size() && gap_left == 0) begin
                in_ch.valid <= 1'b1;
                in_ch.limit <= limit_list[sent];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
                in_ch.limit <= LIMIT_W'($urandom_range(0, (1 << LIMIT_W) - 1));
                if (gap_left > 0) gap_left--;
            end
        end
        sending_done = 1'b1;
    end

    // Receiver: check each count, stall on shifting patterns, hold off once.
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        bit hold_done;
        out_ch.ready <= 1'b0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);

        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                counts_seen++;
                if (pending_counts.size() == 0) begin
                    $error("prime_count: expected none, got %0d", out_ch.prime_count);
                    fail_count++;
                end else begin
                    if (out_ch.prime_count !== pending_counts[0]) begin
                        $error("prime_count: expected %0d, got %0d",
                               pending_counts[0], out_ch.prime_count);
                        fail_count++;
                    end
                    void'(pending_counts.pop_front());
                end
            end
            // Start the long hold-off once, so the block backs up its input.
            if (!hold_done && counts_seen == HOLD_AT_COUNT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(1, 40);
                end
                mode_left--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if no item moves for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// ----- prime_count_sieve.f -----
+incdir+hw/rtl
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_if.sv
hw/rtl/pcs_ctrl.sv
hw/rtl/pcs_datapath.sv
hw/rtl/prime_count_sieve.sv
hw/rtl/pcs_checker.sv
sim/prime_count_sieve_test.sv
